/* design/fvti_pkg.sv */
// Package for the flag vector block: beat types, op codes, sizes and search helpers.
package fvti_pkg;

    localparam int FLAG_W     = 64;
    localparam int MAX_STATES = 64;
    localparam int IDX_W      = $clog2(FLAG_W);
    localparam int CNT_W      = $clog2(FLAG_W + 1);
    localparam logic [CNT_W-1:0] ACTIVE_RESET = CNT_W'(FLAG_W);

    typedef enum logic [3:0] {
        OP_QUERY   = 4'd0,
        OP_SET     = 4'd1,
        OP_TOGGLE  = 4'd2,
        OP_SAVE    = 4'd3,
        OP_RESTORE = 4'd4,
        OP_CLEAR   = 4'd5,
        OP_SET_ALL = 4'd6,
        OP_DEFAULT = 4'd7,
        OP_RANGE   = 4'd8,
        OP_INVERT  = 4'd9
    } op_e;

    typedef struct packed {
        logic [3:0]       op;
        logic [IDX_W-1:0] index;
        logic             value;
        logic             exclusive;
        logic [IDX_W-1:0] range_end;
    } in_beat_t;

    typedef struct packed {
        logic             flag_at_index;
        logic [IDX_W-1:0] tracked_index;
        logic             tracked_valid;
        logic [IDX_W-1:0] first_set_index;
        logic             any_set;
        logic [IDX_W-1:0] first_match_index;
        logic             match_found;
        logic [CNT_W-1:0] set_count;
        logic             single_set;
    } out_beat_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] pos;
    } lowest_t;

    // priority encoder, lowest set bit wins
    function automatic lowest_t lowest(input logic [FLAG_W-1:0] v);
        lowest_t r;
        r = '0;
        for (int i = FLAG_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                r.found = 1'b1;
                r.pos   = IDX_W'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] ones(input logic [FLAG_W-1:0] v);
        logic [CNT_W-1:0] c;
        c = '0;
        for (int i = 0; i < FLAG_W; i++) begin
            c = c + CNT_W'(v[i]);
        end
        return c;
    endfunction

endpackage

/* design/flag_vector_with_tracked_index.sv */
// Top level of the flag vector with tracked index, save/restore and reporting.
//
// Usage:
//   s_valid/s_ready/s_data carry one operation beat (op, index, value, exclusive,
//   range_end). m_valid/m_ready/m_data return one report beat per operation,
//   in order. cfg_valid/cfg_ready/cfg_data write active_count (flags in use);
//   cfg_ready is always high, write it only while the block is idle.
//
// Pipeline: input register -> state update (flags, tracked index, saved copy)
// and snapshot register -> report logic (popcount, two priority encoders) ->
// result register, which drives m_valid and m_data. One beat is taken every
// cycle while m_ready stays high. The rate is set by the state update loop:
// each beat's flag update finishes in the cycle it leaves the input register.
// Reset (aresetn low at a clock edge) clears all flags, the saved copy, the
// tracked index, empties the pipeline and sets active_count to 64.
// When m_ready is low the result holds, the snapshot and input registers
// fill in turn, and then s_ready drops; nothing is lost or repeated.
module flag_vector_with_tracked_index (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  fvti_pkg::in_beat_t          s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output fvti_pkg::out_beat_t         m_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [fvti_pkg::CNT_W-1:0]  cfg_data
);
    import fvti_pkg::*;

    // ---------------- registers ----------------
    logic [CNT_W-1:0]  active_count_reg;

    logic              in_valid_reg;
    in_beat_t          in_beat_reg;

    logic [FLAG_W-1:0] flags_reg,  flags_next;
    logic [FLAG_W-1:0] saved_reg,  saved_next;
    logic [IDX_W-1:0]  trk_pos_reg, trk_pos_next;
    logic              trk_ok_reg,  trk_ok_next;
    logic [IDX_W-1:0]  sv_pos_reg,  sv_pos_next;
    logic              sv_ok_reg,   sv_ok_next;

    // snapshot of the vector after one beat's update
    logic              mid_valid_reg;
    logic [FLAG_W-1:0] mid_used_reg,  mid_used_next;
    logic [FLAG_W-1:0] mid_cand_reg,  mid_cand_next;
    logic              mid_fai_reg,   mid_fai_next;
    logic [IDX_W-1:0]  mid_trk_reg,   mid_trk_next;
    logic              mid_trk_ok_reg;

    logic              out_valid_reg;
    out_beat_t         out_reg, out_next;

    // ---------------- flow control ----------------
    logic out_load, mid_load;

    assign out_load  = mid_valid_reg && (!out_valid_reg || m_ready);
    assign mid_load  = in_valid_reg && (!mid_valid_reg || out_load);
    assign s_ready   = !in_valid_reg || mid_load;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    // ---------------- flags in use ----------------
    logic [CNT_W-1:0]  n_use;
    logic [FLAG_W-1:0] mask;
    logic [FLAG_W-1:0] bit_sel;
    logic              valid_idx;

    always_comb begin
        n_use = (active_count_reg > CNT_W'(MAX_STATES)) ? CNT_W'(MAX_STATES)
                                                        : active_count_reg;
        if (n_use == '0) begin
            n_use = CNT_W'(1);
        end
        for (int i = 0; i < FLAG_W; i++) begin
            mask[i]    = CNT_W'(i) < n_use;
            bit_sel[i] = in_beat_reg.index == IDX_W'(i);
        end
        valid_idx = {1'b0, in_beat_reg.index} < n_use;
    end

    // ---------------- state update ----------------
    logic              val_eff, excl_eff;
    logic [IDX_W-1:0]  rend_c;
    logic [FLAG_W-1:0] range_bits;
    logic [FLAG_W-1:0] cleared;
    lowest_t           lo_clr, lo_inv;

    always_comb begin
        flags_next   = flags_reg;
        saved_next   = saved_reg;
        trk_pos_next = trk_pos_reg;
        trk_ok_next  = trk_ok_reg;
        sv_pos_next  = sv_pos_reg;
        sv_ok_next   = sv_ok_reg;

        val_eff  = in_beat_reg.value;
        excl_eff = in_beat_reg.exclusive;
        if (in_beat_reg.op == OP_TOGGLE && valid_idx) begin
            // toggle turning on always clears the others
            val_eff  = !flags_reg[in_beat_reg.index];
            excl_eff = 1'b1;
        end

        rend_c = ({1'b0, in_beat_reg.range_end} > n_use - CNT_W'(1))
                 ? IDX_W'(n_use - CNT_W'(1)) : in_beat_reg.range_end;
        for (int i = 0; i < FLAG_W; i++) begin
            range_bits[i] = (IDX_W'(i) >= in_beat_reg.index) && (IDX_W'(i) <= rend_c);
        end

        cleared = flags_reg & ~bit_sel;
        lo_clr  = lowest(cleared & mask);
        lo_inv  = lowest(~flags_reg & mask);

        case (op_e'(in_beat_reg.op))
            OP_SET, OP_TOGGLE: begin
                if (valid_idx) begin
                    if (val_eff) begin
                        flags_next   = excl_eff ? ((flags_reg | bit_sel) & ~(mask & ~bit_sel))
                                                : (flags_reg | bit_sel);
                        trk_pos_next = in_beat_reg.index;
                        trk_ok_next  = 1'b1;
                    end else begin
                        flags_next = cleared;
                        // clearing the tracked flag moves tracking to the lowest set one
                        if (trk_ok_reg && trk_pos_reg == in_beat_reg.index) begin
                            trk_pos_next = lo_clr.pos;
                            trk_ok_next  = lo_clr.found;
                        end
                    end
                end
            end
            OP_SAVE: begin
                saved_next  = flags_reg;
                sv_pos_next = trk_pos_reg;
                sv_ok_next  = trk_ok_reg;
            end
            OP_RESTORE: begin
                flags_next   = saved_reg;
                trk_pos_next = sv_pos_reg;
                trk_ok_next  = sv_ok_reg;
            end
            OP_CLEAR: begin
                flags_next   = '0;
                trk_pos_next = '0;
                trk_ok_next  = 1'b0;
            end
            OP_SET_ALL: begin
                flags_next   = in_beat_reg.value ? mask : '0;
                trk_pos_next = '0;
                trk_ok_next  = in_beat_reg.value;
            end
            OP_DEFAULT: begin
                flags_next   = FLAG_W'(1);
                trk_pos_next = '0;
                trk_ok_next  = 1'b1;
            end
            OP_RANGE: begin
                if (valid_idx) begin
                    // an empty range just clears everything
                    if (in_beat_reg.value && rend_c >= in_beat_reg.index) begin
                        flags_next   = range_bits;
                        trk_pos_next = in_beat_reg.index;
                        trk_ok_next  = 1'b1;
                    end else begin
                        flags_next   = '0;
                        trk_pos_next = '0;
                        trk_ok_next  = 1'b0;
                    end
                end
            end
            OP_INVERT: begin
                flags_next   = ~flags_reg & mask;
                trk_pos_next = lo_inv.pos;
                trk_ok_next  = lo_inv.found;
            end
            default: begin
                // query and unused codes leave the state alone
            end
        endcase

        mid_used_next = flags_next & mask;
        mid_cand_next = val_eff ? mid_used_next : (~flags_next & mask);
        mid_fai_next  = valid_idx && flags_next[in_beat_reg.index];
        mid_trk_next  = trk_ok_next ? trk_pos_next : '0;
    end

    // ---------------- report logic ----------------
    lowest_t          lo_used, lo_match;
    logic [CNT_W-1:0] cnt;

    always_comb begin
        lo_used  = lowest(mid_used_reg);
        lo_match = lowest(mid_cand_reg);
        cnt      = ones(mid_used_reg);

        out_next.flag_at_index     = mid_fai_reg;
        out_next.tracked_index     = mid_trk_reg;
        out_next.tracked_valid     = mid_trk_ok_reg;
        out_next.first_set_index   = lo_used.pos;
        out_next.any_set           = lo_used.found;
        out_next.first_match_index = lo_match.pos;
        out_next.match_found       = lo_match.found;
        out_next.set_count         = cnt;
        out_next.single_set        = cnt == CNT_W'(1);
    end

    // ---------------- clocked ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_count_reg <= ACTIVE_RESET;
            in_valid_reg     <= 1'b0;
            mid_valid_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
            flags_reg        <= '0;
            saved_reg        <= '0;
            trk_pos_reg      <= '0;
            trk_ok_reg       <= 1'b0;
            sv_pos_reg       <= '0;
            sv_ok_reg        <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                active_count_reg <= cfg_data;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (mid_load) begin
                mid_valid_reg <= 1'b1;
                flags_reg     <= flags_next;
                saved_reg     <= saved_next;
                trk_pos_reg   <= trk_pos_next;
                trk_ok_reg    <= trk_ok_next;
                sv_pos_reg    <= sv_pos_next;
                sv_ok_reg     <= sv_ok_next;
            end else if (out_load) begin
                mid_valid_reg <= 1'b0;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_beat_reg <= s_data;
        end
        if (mid_load) begin
            mid_used_reg   <= mid_used_next;
            mid_cand_reg   <= mid_cand_next;
            mid_fai_reg    <= mid_fai_next;
            mid_trk_reg    <= mid_trk_next;
            mid_trk_ok_reg <= trk_ok_next;
        end
        if (out_load) begin
            out_reg <= out_next;
        end
    end

    // ---------------- assertions ----------------
    a_any_vs_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.any_set == (m_data.set_count != '0)))
        else $error("any_set disagrees with set_count");

    a_single_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.single_set) |-> (m_data.set_count == CNT_W'(1) && m_data.any_set))
        else $error("single_set without exactly one flag");

    a_untracked_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.tracked_valid) |-> (m_data.tracked_index == '0))
        else $error("tracked_index nonzero while not tracked");

    a_stall_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && mid_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled while pipeline has room");

    a_mid_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        mid_load |=> mid_valid_reg)
        else $error("snapshot stage lost a beat");

endmodule

/* bench/tb_flag_vector_with_tracked_index.sv */
// Self-checking bench for the flag vector with tracked index: directed and random op beats.
module tb_flag_vector_with_tracked_index;
    timeunit 1ns;
    timeprecision 1ps;

    import fvti_pkg::*;

    // run length guard for ~730 beats, with a wide margin over the worst case
    localparam int CYCLE_LIMIT = 200000;
    // settle time after the last report, longer than the pipe
    localparam int TAIL_CYCLES = 12;
    // op codes above the defined set decode as a plain query
    localparam logic [3:0] OP_SPARE_BASE = 4'd10;
    localparam logic [3:0] OP_SPARE_TOP  = 4'd15;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    in_beat_t         s_data    = '0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    out_beat_t        m_data;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CNT_W-1:0] cfg_data  = '0;

    // when set, both sides run back to back with no idle cycles
    bit calm = 1'b0;

    int unsigned cycle_count = 0;
    int unsigned fault_count = 0;

    // reports still owed by the block, oldest first
    out_beat_t expected_reports[$];

    // shadow copy of the block state
    logic [FLAG_W-1:0] flag_bits     = '0;
    logic [FLAG_W-1:0] saved_bits    = '0;
    logic [IDX_W-1:0]  trk_pos       = '0;
    logic              trk_ok        = 1'b0;
    logic [IDX_W-1:0]  saved_trk_pos = '0;
    logic              saved_trk_ok  = 1'b0;
    logic [CNT_W-1:0]  active_cnt    = ACTIVE_RESET;

    flag_vector_with_tracked_index u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5ns aclk = ~aclk;

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    // flags in use: register clamped to the vector size, zero acts as one
    function automatic int unsigned flags_in_use();
        int unsigned n;
        n = active_cnt;
        if (n > MAX_STATES) n = MAX_STATES;
        if (n > FLAG_W) n = FLAG_W;
        if (n == 0) n = 1;
        return n;
    endfunction

    function automatic logic [FLAG_W-1:0] low_mask(input int unsigned n);
        return (n >= FLAG_W) ? '1 : ((FLAG_W'(1) << n) - FLAG_W'(1));
    endfunction

    // lowest set bit; pos is 0 when nothing is set
    function automatic bit find_lowest(input logic [FLAG_W-1:0] v,
                                       output logic [IDX_W-1:0] pos);
        find_lowest = 1'b0;
        pos = '0;
        for (int i = 0; i < FLAG_W; i++) begin
            if (v[i] && !find_lowest) begin
                find_lowest = 1'b1;
                pos = IDX_W'(i);
            end
        end
    endfunction

    // apply one op beat to the shadow state and return the report it yields
    function automatic out_beat_t predict_report(input in_beat_t b);
        int unsigned       n;
        int unsigned       cnt;
        logic [FLAG_W-1:0] mask;
        logic [FLAG_W-1:0] one_hot;
        logic [FLAG_W-1:0] used;
        logic [FLAG_W-1:0] cand;
        logic [IDX_W-1:0]  idx;
        logic [IDX_W-1:0]  last;
        logic [IDX_W-1:0]  pos;
        logic              val;
        logic              excl;
        logic              idx_ok;
        out_beat_t         r;

        n       = flags_in_use();
        mask    = low_mask(n);
        idx     = b.index;
        last    = b.range_end;
        val     = b.value;
        excl    = b.exclusive;
        one_hot = FLAG_W'(1) << idx;
        idx_ok  = (idx < n);

        case (b.op)
            OP_SET, OP_TOGGLE: begin
                if (idx_ok) begin
                    // toggle turns into a set of the opposite value, always exclusive;
                    // the new value is also what the match search looks for
                    if (b.op == OP_TOGGLE) begin
                        val  = !flag_bits[idx];
                        excl = 1'b1;
                    end
                    if (val) begin
                        flag_bits = flag_bits | one_hot;
                        trk_pos   = idx;
                        trk_ok    = 1'b1;
                        if (excl) flag_bits = flag_bits & ~(mask & ~one_hot);
                    end else begin
                        flag_bits = flag_bits & ~one_hot;
                        // clearing the tracked flag moves tracking to the lowest set one
                        if (trk_ok && trk_pos == idx)
                            trk_ok = find_lowest(flag_bits & mask, trk_pos);
                    end
                end
            end
            OP_SAVE: begin
                saved_bits    = flag_bits;
                saved_trk_pos = trk_pos;
                saved_trk_ok  = trk_ok;
            end
            OP_RESTORE: begin
                flag_bits = saved_bits;
                trk_pos   = saved_trk_pos;
                trk_ok    = saved_trk_ok;
            end
            OP_CLEAR: begin
                flag_bits = '0;
                trk_pos   = '0;
                trk_ok    = 1'b0;
            end
            OP_SET_ALL: begin
                flag_bits = val ? mask : '0;
                trk_pos   = '0;
                trk_ok    = val;
            end
            OP_DEFAULT: begin
                flag_bits = FLAG_W'(1);
                trk_pos   = '0;
                trk_ok    = 1'b1;
            end
            OP_RANGE: begin
                if (idx_ok) begin
                    if (int'(last) > int'(n) - 1) last = IDX_W'(n - 1);
                    flag_bits = '0;
                    trk_pos   = '0;
                    trk_ok    = 1'b0;
                    // an empty range (end below start) just leaves everything clear
                    if (last >= idx && val) begin
                        flag_bits = low_mask(int'(last) + 1) & ~low_mask(idx);
                        trk_pos   = idx;
                        trk_ok    = 1'b1;
                    end
                end
            end
            OP_INVERT: begin
                flag_bits = ~flag_bits & mask;
                trk_ok    = find_lowest(flag_bits & mask, trk_pos);
            end
            default: ;
        endcase

        used = flag_bits & mask;
        cnt  = $countones(used);
        cand = val ? used : (~flag_bits & mask);

        r.flag_at_index   = idx_ok ? flag_bits[idx] : 1'b0;
        r.tracked_index   = trk_ok ? trk_pos : '0;
        r.tracked_valid   = trk_ok;
        r.any_set         = find_lowest(used, pos);
        r.first_set_index = pos;
        r.match_found     = find_lowest(cand, pos);
        r.first_match_index = pos;
        r.set_count       = CNT_W'(cnt);
        r.single_set      = (cnt == 1);
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Report checking
    // ---------------------------------------------------------------

    task automatic note_fault(input string what, input out_beat_t want, input out_beat_t got);
        fault_count++;
        if (fault_count <= 10) begin
            $display("%0t %0s: want at=%0b trk=%0d/%0b first=%0d/%0b match=%0d/%0b cnt=%0d one=%0b",
                     $time, what, want.flag_at_index, want.tracked_index, want.tracked_valid,
                     want.first_set_index, want.any_set, want.first_match_index,
                     want.match_found, want.set_count, want.single_set);
            $display("    got at=%0b trk=%0d/%0b first=%0d/%0b match=%0d/%0b cnt=%0d one=%0b",
                     got.flag_at_index, got.tracked_index, got.tracked_valid,
                     got.first_set_index, got.any_set, got.first_match_index,
                     got.match_found, got.set_count, got.single_set);
        end
    endtask

    // every report beat is matched against the oldest prediction
    always @(posedge aclk) begin : check_reports
        out_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_reports.size() == 0) begin
                note_fault("report with nothing pending", '0, m_data);
            end else begin
                want = expected_reports.pop_front();
                if (m_data.flag_at_index     !== want.flag_at_index     ||
                    m_data.tracked_index     !== want.tracked_index     ||
                    m_data.tracked_valid     !== want.tracked_valid     ||
                    m_data.first_set_index   !== want.first_set_index   ||
                    m_data.any_set           !== want.any_set           ||
                    m_data.first_match_index !== want.first_match_index ||
                    m_data.match_found       !== want.match_found       ||
                    m_data.set_count         !== want.set_count         ||
                    m_data.single_set        !== want.single_set)
                    note_fault("report mismatch", want, m_data);
            end
        end
    end

    // report sink: random stall before each beat, none while calm
    initial begin : report_sink
        int unsigned stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 13);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    function automatic in_beat_t op_beat(input logic [3:0] op, input int unsigned idx,
                                         input bit val, input bit excl,
                                         input int unsigned last);
        in_beat_t b;
        b.op        = op;
        b.index     = IDX_W'(idx);
        b.value     = val;
        b.exclusive = excl;
        b.range_end = IDX_W'(last);
        return b;
    endfunction

    // one op beat: random gap, then hold valid until taken; valid stays up on return
    task automatic send_beat(input in_beat_t b);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 13);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge aclk); while (!s_ready);
        expected_reports.push_back(predict_report(b));
    endtask

    // drop valid and wait until every owed report is back
    task automatic drain();
        s_valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge aclk);
    endtask

    // register write only with the pipe empty
    task automatic set_active_count(input int unsigned count);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= CNT_W'(count);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        active_cnt = CNT_W'(count);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    task automatic test_after_reset();
        send_beat(op_beat(OP_QUERY, 63, 1'b1, 1'b0, 63));
    endtask

    task automatic test_set_and_clear();
        send_beat(op_beat(OP_SET, 0, 1'b1, 1'b0, 0));
        send_beat(op_beat(OP_SET, 63, 1'b1, 1'b0, 0));
        // clear the tracked flag: tracking falls back to flag 0
        send_beat(op_beat(OP_SET, 63, 1'b0, 1'b0, 0));
        send_beat(op_beat(OP_SET, 10, 1'b1, 1'b1, 0));
        send_beat(op_beat(OP_SET, 20, 1'b1, 1'b0, 0));
        // clear of an untracked flag keeps tracking on 20
        send_beat(op_beat(OP_SET, 10, 1'b0, 1'b0, 0));
    endtask

    task automatic test_toggle();
        send_beat(op_beat(OP_TOGGLE, 7, 1'b0, 1'b0, 0));
        send_beat(op_beat(OP_TOGGLE, 7, 1'b1, 1'b0, 0));
    endtask

    task automatic test_save_restore();
        send_beat(op_beat(OP_SAVE, 0, 1'b0, 1'b0, 0));
        send_beat(op_beat(OP_CLEAR, 0, 1'b0, 1'b0, 0));
        send_beat(op_beat(OP_RESTORE, 0, 1'b1, 1'b0, 0));
    endtask

    task automatic test_bulk_ops();
        send_beat(op_beat(OP_SET_ALL, 0, 1'b1, 1'b0, 0));
        send_beat(op_beat(OP_INVERT, 3, 1'b0, 1'b0, 0));
        send_beat(op_beat(OP_SET_ALL, 0, 1'b0, 1'b1, 0));
        send_beat(op_beat(OP_DEFAULT, 0, 1'b0, 1'b0, 0));
    endtask

    task automatic test_range();
        send_beat(op_beat(OP_RANGE, 4, 1'b1, 1'b0, 9));
        // end below start: everything cleared, nothing tracked
        send_beat(op_beat(OP_RANGE, 9, 1'b1, 1'b0, 4));
        send_beat(op_beat(OP_RANGE, 60, 1'b1, 1'b0, 63));
        send_beat(op_beat(OP_RANGE, 2, 1'b0, 1'b0, 5));
    endtask

    task automatic test_spare_ops();
        send_beat(op_beat(OP_SPARE_TOP, 5, 1'b1, 1'b1, 63));
    endtask

    // narrow flag count: out-of-use indices, clipping, stale tracking
    task automatic test_narrow_count();
        send_beat(op_beat(OP_SET, 40, 1'b1, 1'b0, 0));
        send_beat(op_beat(OP_SAVE, 0, 1'b0, 1'b0, 0));
        set_active_count(8);
        // tracked index 40 is reported as it stands
        send_beat(op_beat(OP_QUERY, 40, 1'b0, 1'b0, 0));
        send_beat(op_beat(OP_SET, 9, 1'b1, 1'b1, 0));
        send_beat(op_beat(OP_RANGE, 2, 1'b1, 1'b0, 60));
        send_beat(op_beat(OP_RESTORE, 0, 1'b0, 1'b0, 0));
        set_active_count(1);
        send_beat(op_beat(OP_SET, 0, 1'b1, 1'b0, 0));
        send_beat(op_beat(OP_TOGGLE, 5, 1'b0, 1'b0, 0));
        send_beat(op_beat(OP_RANGE, 3, 1'b1, 1'b0, 3));
    endtask

    // random mix over several flag counts; mostly in-use indices
    task automatic test_random_mix();
        int unsigned counts[7];
        int unsigned n;
        int unsigned pick;
        int unsigned idx;
        int unsigned last;
        logic [3:0]  op;
        counts = '{64, 1, 2, 63, 0, 33, 64};
        counts[4] = $urandom_range(1, 64);
        for (int ph = 0; ph < 7; ph++) begin
            set_active_count(counts[ph]);
            calm = (ph % 3 == 2);
            n = flags_in_use();
            for (int k = 0; k < 100; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 30)      op = OP_SET;
                else if (pick < 45) op = OP_TOGGLE;
                else if (pick < 52) op = OP_SAVE;
                else if (pick < 59) op = OP_RESTORE;
                else if (pick < 63) op = OP_CLEAR;
                else if (pick < 67) op = OP_SET_ALL;
                else if (pick < 71) op = OP_DEFAULT;
                else if (pick < 83) op = OP_RANGE;
                else if (pick < 89) op = OP_INVERT;
                else if (pick < 95) op = OP_QUERY;
                else op = 4'($urandom_range(OP_SPARE_BASE, OP_SPARE_TOP));
                idx = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63)
                                                  : $urandom_range(0, n - 1);
                if ($urandom_range(0, 1) == 0) begin
                    last = $urandom_range(0, 63);
                end else begin
                    last = idx + $urandom_range(0, 5);
                    if (last > 63) last = 63;
                end
                send_beat(op_beat(op, idx, 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)), last));
            end
        end
        calm = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_after_reset();
        test_set_and_clear();
        test_toggle();
        test_save_restore();
        test_bulk_ops();
        test_range();
        test_spare_ops();
        test_narrow_count();
        test_random_mix();
        drain();
        // catch any stray report after the last one owed
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fault_count == 0 && expected_reports.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
